// File: rtl/sprite_blitter_wrap_flip_unit_macros.svh
// assertion macros shared by the sprite blitter rtl
`ifndef SPRITE_BLITTER_WRAP_FLIP_UNIT_MACROS_SVH
`define SPRITE_BLITTER_WRAP_FLIP_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define SBWF_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("sbwf same-cycle check failed");

// next-cycle implication, checked out of reset
`define SBWF_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("sbwf next-cycle check failed");

`endif

// File: rtl/sbwf_pkg.sv
// shared types and constants of the sprite blitter
package sbwf_pkg;

	// default screen size
	localparam int SCREEN_WIDTH_DEF  = 256;
	localparam int SCREEN_HEIGHT_DEF = 256;

	// field widths
	localparam int OP_W      = 2;
	localparam int ADDR_W    = 24;
	localparam int COORD_W   = 8;
	localparam int SIZE_W    = 9;
	localparam int INDEX_W   = 8;
	localparam int FLAGS_W   = 6;
	localparam int OFFSET_W  = 17;
	localparam int COUNT_W   = 20;
	localparam int PADDR_W   = 16;
	localparam int COLOR_W   = 32;
	localparam int ORIGIN_SPAN = 1 << COORD_W;

	// counter and quota
	localparam logic [COUNT_W-1:0] QUOTA_RESET = 20'd65536;
	localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;
	localparam logic [7:0]         ALPHA_OPAQUE = 8'hFF;

	// draw flag bit positions
	localparam int FLAG_HFLIP       = 0;
	localparam int FLAG_VFLIP       = 1;
	localparam int FLAG_AFTER_H     = 2;
	localparam int FLAG_AFTER_V     = 3;
	localparam int FLAG_NO_BEFORE_H = 4;
	localparam int FLAG_NO_BEFORE_V = 5;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_FRAME  = 2'd0,
		OP_HEADER = 2'd1,
		OP_PIXEL  = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// input word
	typedef struct packed {
		logic [OP_W-1:0]    operation;
		logic [ADDR_W-1:0]  sprite_address;
		logic [COORD_W-1:0] pos_x;
		logic [COORD_W-1:0] pos_y;
		logic [SIZE_W-1:0]  sprite_width;
		logic [SIZE_W-1:0]  sprite_height;
		logic [INDEX_W-1:0] transparent_index;
		logic [FLAGS_W-1:0] draw_flags;
		logic [INDEX_W-1:0] pixel_index;
	} in_word_t;

	// result word
	typedef struct packed {
		logic               write_enable;
		logic [PADDR_W-1:0] pixel_address;
		logic [COLOR_W-1:0] pixel_color;
		logic [ADDR_W-1:0]  source_address;
		logic               sprite_accepted;
		logic               last_pixel;
		logic [COUNT_W-1:0] drawn_count;
	} out_word_t;

	// per-axis draw controls
	typedef struct packed {
		logic flip;
		logic draw_after;
		logic no_draw_before;
	} axis_ctl_t;

endpackage

// File: rtl/sbwf_axis.sv
// one axis of the sprite mapping: flip, screen wrap and draw masks
module sbwf_axis #(
	parameter int SCREEN = sbwf_pkg::SCREEN_WIDTH_DEF
) (
	input  logic [sbwf_pkg::SIZE_W-1:0]  idx,
	input  logic [sbwf_pkg::SIZE_W-1:0]  size,
	input  logic [sbwf_pkg::COORD_W-1:0] origin,
	input  sbwf_pkg::axis_ctl_t          ctl,
	output logic [sbwf_pkg::COORD_W-1:0] wrapped,
	output logic                         masked
);
	import sbwf_pkg::*;

	localparam int SUM_W = SIZE_W + 1;
	localparam logic [SUM_W-1:0] SCREEN_EXT = SUM_W'(SCREEN);

	typedef logic [COORD_W-1:0] mod_tab_t [ORIGIN_SPAN];

	// origin modulo screen, built at elaboration
	function automatic mod_tab_t build_mod_tab();
		mod_tab_t t;
		for (int i = 0; i < ORIGIN_SPAN; i++) begin
			t[i] = COORD_W'(i % SCREEN);
		end
		return t;
	endfunction

	localparam mod_tab_t MOD_TAB = build_mod_tab();

	logic [SIZE_W-1:0]  pos;
	logic [COORD_W-1:0] origin_mod;
	logic [SUM_W-1:0]   sum;
	logic [SUM_W-1:0]   reduced;

	// position inside the sprite after flip
	assign pos = ctl.flip ? (size - idx - SIZE_W'(1)) : idx;

	// pos is below the screen size, so one subtract finishes the wrap
	assign origin_mod = MOD_TAB[origin];
	assign sum        = {1'b0, pos} + SUM_W'(origin_mod);
	assign reduced    = (sum >= SCREEN_EXT) ? (sum - SCREEN_EXT) : sum;
	assign wrapped    = reduced[COORD_W-1:0];

	// before-wrap and after-wrap masks
	assign masked = (wrapped >= origin) ? ctl.no_draw_before : !ctl.draw_after;

endmodule

// File: rtl/sprite_blitter_wrap_flip_unit.sv
// sprite blitter top level: header latch, pixel mapping, drawn-pixel counter
//
//  channel   dir  handshake                    payload
//  in        in   in_valid / in_ready          in_data (in_word_t)
//  out       out  out_valid / out_ready        out_data (out_word_t)
//  cfg       in   cfg_write_enable             cfg_write_data (pixel quota)
//
//  one word a cycle while the output is not stalled: every word is mapped in a single pass and its result
//  lands in the output register at the accepting edge.
//  a stalled result is held while a new word is taken
//  in the same cycle the held one leaves.
//  reset clears the active flag, position, counter and result valid and sets the quota to 65536.
`include "sprite_blitter_wrap_flip_unit_macros.svh"

module sprite_blitter_wrap_flip_unit #(
	parameter int SCREEN_WIDTH  = sbwf_pkg::SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = sbwf_pkg::SCREEN_HEIGHT_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  sbwf_pkg::in_word_t           in_data,
	output logic                         out_valid,
	input  logic                         out_ready,
	output sbwf_pkg::out_word_t          out_data,
	input  logic                         cfg_write_enable,
	input  logic [sbwf_pkg::COUNT_W-1:0] cfg_write_data
);
	import sbwf_pkg::*;

	localparam logic [SIZE_W:0]    SW_EXT = (SIZE_W + 1)'(SCREEN_WIDTH);
	localparam logic [SIZE_W:0]    SH_EXT = (SIZE_W + 1)'(SCREEN_HEIGHT);
	localparam logic [PADDR_W-1:0] SW_ROW = PADDR_W'(SCREEN_WIDTH);

	// quota register and sprite state
	logic [COUNT_W-1:0] quota_q;
	logic [ADDR_W-1:0]  base_q;
	logic [COORD_W-1:0] origin_x_q;
	logic [COORD_W-1:0] origin_y_q;
	logic [SIZE_W-1:0]  width_q;
	logic [SIZE_W-1:0]  height_q;
	logic [INDEX_W-1:0] skip_q;
	logic [FLAGS_W-1:0] flags_q;
	logic               active_q;
	logic [SIZE_W-1:0]  row_q;
	logic [SIZE_W-1:0]  col_q;
	logic [OFFSET_W-1:0] offset_q;
	logic [COUNT_W-1:0] count_q;

	// result register
	logic      out_valid_q;
	out_word_t out_data_q;

	// next values
	logic               accept;
	logic               latch_header;
	logic               nxt_active;
	logic [SIZE_W-1:0]  nxt_row;
	logic [SIZE_W-1:0]  nxt_col;
	logic [OFFSET_W-1:0] nxt_offset;
	logic [COUNT_W-1:0] nxt_count;
	out_word_t          result;

	// mapping
	axis_ctl_t          ctl_x;
	axis_ctl_t          ctl_y;
	logic [COORD_W-1:0] wx;
	logic [COORD_W-1:0] wy;
	logic               mask_x;
	logic               mask_y;
	logic               draw;
	logic               col_end;
	logic               row_end;
	logic               refuse;

	// rgb332 to argb8888
	function automatic logic [COLOR_W-1:0] expand_color(input logic [INDEX_W-1:0] c);
		logic [2:0] r;
		logic [2:0] g;
		logic [1:0] b;
		r = c[7:5];
		g = c[4:2];
		b = c[1:0];
		return {ALPHA_OPAQUE, r, r, r[2:1], g, g, g[2:1], b, b, b, b};
	endfunction

	assign accept    = in_valid && in_ready;
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// axis controls from the latched flags
	assign ctl_x = '{flip: flags_q[FLAG_HFLIP], draw_after: flags_q[FLAG_AFTER_H],
		no_draw_before: flags_q[FLAG_NO_BEFORE_H]};
	assign ctl_y = '{flip: flags_q[FLAG_VFLIP], draw_after: flags_q[FLAG_AFTER_V],
		no_draw_before: flags_q[FLAG_NO_BEFORE_V]};

	sbwf_axis #(.SCREEN(SCREEN_WIDTH)) u_axis_x (
		.idx     (col_q),
		.size    (width_q),
		.origin  (origin_x_q),
		.ctl     (ctl_x),
		.wrapped (wx),
		.masked  (mask_x)
	);

	sbwf_axis #(.SCREEN(SCREEN_HEIGHT)) u_axis_y (
		.idx     (row_q),
		.size    (height_q),
		.origin  (origin_y_q),
		.ctl     (ctl_y),
		.wrapped (wy),
		.masked  (mask_y)
	);

	assign draw    = !mask_x && !mask_y && (in_data.pixel_index != skip_q);
	assign col_end = ({1'b0, col_q} + (SIZE_W + 1)'(1)) >= {1'b0, width_q};
	assign row_end = ({1'b0, row_q} + (SIZE_W + 1)'(1)) >= {1'b0, height_q};
	assign refuse  = (count_q >= quota_q) || ({1'b0, in_data.sprite_width} > SW_EXT)
		|| ({1'b0, in_data.sprite_height} > SH_EXT);

	// per-word state update and result
	always_comb begin
		latch_header = 1'b0;
		nxt_active   = active_q;
		nxt_row      = row_q;
		nxt_col      = col_q;
		nxt_offset   = offset_q;
		nxt_count    = count_q;
		result       = '0;
		case (op_t'(in_data.operation))
			OP_FRAME: begin
				nxt_count = '0;
			end
			OP_HEADER: begin
				if (refuse) begin
					nxt_active = 1'b0;
				end else begin
					latch_header = 1'b1;
					nxt_row      = '0;
					nxt_col      = '0;
					nxt_offset   = '0;
					nxt_active   = (in_data.sprite_width != '0) && (in_data.sprite_height != '0);
				end
			end
			OP_PIXEL: begin
				if (active_q) begin
					result.source_address = base_q + ADDR_W'(offset_q);
					if (draw) begin
						result.write_enable  = 1'b1;
						result.pixel_address = PADDR_W'({8'b0, wy} * SW_ROW) + PADDR_W'(wx);
						result.pixel_color   = expand_color(in_data.pixel_index);
						if (count_q != COUNT_MAX) begin
							nxt_count = count_q + COUNT_W'(1);
						end
					end
					nxt_offset = offset_q + OFFSET_W'(1);
					if (col_end) begin
						nxt_col = '0;
						if (row_end) begin
							result.last_pixel = 1'b1;
							nxt_active        = 1'b0;
							nxt_row           = '0;
						end else begin
							nxt_row = row_q + SIZE_W'(1);
						end
					end else begin
						nxt_col = col_q + SIZE_W'(1);
					end
				end
			end
			default: begin
			end
		endcase
		result.sprite_accepted = nxt_active;
		result.drawn_count     = nxt_count;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quota_q     <= QUOTA_RESET;
			active_q    <= 1'b0;
			row_q       <= '0;
			col_q       <= '0;
			offset_q    <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_write_enable) begin
				quota_q <= cfg_write_data;
			end
			if (accept) begin
				active_q    <= nxt_active;
				row_q       <= nxt_row;
				col_q       <= nxt_col;
				offset_q    <= nxt_offset;
				count_q     <= nxt_count;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// header fields and result payload
	always_ff @(posedge clk) begin
		if (accept && latch_header) begin
			base_q     <= in_data.sprite_address;
			origin_x_q <= in_data.pos_x;
			origin_y_q <= in_data.pos_y;
			width_q    <= in_data.sprite_width;
			height_q   <= in_data.sprite_height;
			skip_q     <= in_data.transparent_index;
			flags_q    <= in_data.draw_flags;
		end
		if (accept) begin
			out_data_q <= result;
		end
	end

	// checks
	`SBWF_ASSERT_IMP(a_draw_counted, clk, arst_n,
		out_valid_q && out_data_q.write_enable, out_data_q.drawn_count != '0)
	`SBWF_ASSERT_IMP(a_last_ends_sprite, clk, arst_n,
		out_valid_q && out_data_q.last_pixel, !out_data_q.sprite_accepted)
	`SBWF_ASSERT_IMP(a_active_in_bounds, clk, arst_n,
		active_q, (col_q < width_q) && (row_q < height_q))
	`SBWF_ASSERT_NXT(a_last_clears_active, clk, arst_n,
		accept && result.last_pixel, !active_q && (row_q == '0) && (col_q == '0))

endmodule
